// ===== rtl/seven_segment_scan_with_switch_debounce_core_defines.svh =====
// Assertion macros for the display scan core.
`ifndef SEVEN_SEGMENT_SCAN_WITH_SWITCH_DEBOUNCE_CORE_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_WITH_SWITCH_DEBOUNCE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ssd_pkg.sv =====
`default_nettype none

package ssd_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    localparam int unsigned DIGITS = 4;

    localparam logic [3:0] PRESS_THRESHOLD_RST = 4'd4;
    localparam logic [5:0] RELEASE_HOLD_RST    = 6'd20;

    localparam logic [1:0] CFG_PRESS_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_RELEASE_HOLD    = 2'd1;

    localparam logic [7:0] SEG_BLANK = 8'hFF;
    localparam logic [3:0] DIG_OFF   = 4'hF;

    typedef struct packed {
        logic [7:0] read_data;
        logic       switch_signal;
        logic [7:0] segments_n;
        logic [3:0] digit_enable_n;
    } t_result;

    // Active-low segments g..a in bits 7:1 (a in bit 1), point in bit 0
    function automatic logic [7:0] seg_decode(input logic [3:0] value);
        logic [7:0] seg;
        unique case (value)
            4'h0:    seg = 8'h81;
            4'h1:    seg = 8'hF3;
            4'h2:    seg = 8'h49;
            4'h3:    seg = 8'h61;
            4'h4:    seg = 8'h33;
            4'h5:    seg = 8'h25;
            4'h6:    seg = 8'h05;
            4'h7:    seg = 8'hF1;
            4'h8:    seg = 8'h01;
            4'h9:    seg = 8'h21;
            4'hA:    seg = 8'h7F;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/seven_segment_scan_with_switch_debounce_core.sv =====
// Four-digit multiplexed seven-segment driver with four-switch debounce.
// Input stream: tuser carries the event kind (0 bus write, 1 bus read, 2 scan
// tick), tdata carries the written byte and the switch sample. Every request
// returns exactly one result request on the output stream with the held digit
// enable, held segments, notify line and the byte a bus read would return.
// Throughput: one request per cycle while the skid register is empty, set by
// the single register stage that updates all display and debounce state.
// A two-entry output stage (result register plus skid register) lets the input
// keep taking a request while one result waits; input tready drops only when
// both entries are full, so a stalled receiver stops intake after two results.
// Configuration writes (index 0 press threshold, 1 release hold) are taken
// at any time; other indexes are ignored.
// Reset (synchronous, active low): digits and segments off, all slots blank,
// counters and flags zero, threshold 4, hold 20, output stage empty.
`default_nettype none
`include "seven_segment_scan_with_switch_debounce_core_defines.svh"

module seven_segment_scan_with_switch_debounce_core
    import ssd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // data_byte[7:0], switch_raw[11:8], zero pad
    input  wire logic [1:0]  i_s_tuser,   // action[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // digit_enable_n[3:0], segments_n[11:4],
                                          // switch_signal[12], read_data[20:13], zero pad
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [5:0]  i_cfg_data
);

    logic [3:0]              r_thr;
    logic [5:0]              r_hold;
    logic [DIGITS-1:0][7:0]  r_staged, n_staged;
    logic [DIGITS-1:0][7:0]  r_shown,  n_shown;
    logic [1:0]              r_scan,   n_scan;
    logic [3:0]              r_press,  n_press;
    logic [5:0]              r_rel,    n_rel;
    logic                    r_notify, n_notify;
    logic                    r_signal, n_signal;
    logic [3:0]              r_sw,     n_sw;
    logic [7:0]              r_tx,     n_tx;
    logic [3:0]              r_den,    n_den;
    logic [7:0]              r_dseg,   n_dseg;

    t_result                 r_out, r_skd, n_res;
    logic                    r_out_valid, r_skd_valid;

    logic                    in_acc;
    logic                    out_free;
    logic [7:0]              data_byte;
    logic [3:0]              switch_raw;
    logic [1:0]              slot;
    logic [7:0]              seg_val;
    logic [3:0]              cnt;
    logic [3:0]              lim;
    logic [6:0]              rel;

    assign data_byte  = i_s_tdata[7:0];
    assign switch_raw = i_s_tdata[11:8];
    assign o_s_tready = !r_skd_valid;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    assign slot    = data_byte[5:4];
    assign seg_val = data_byte[6] ? (seg_decode(data_byte[3:0]) & 8'hFE)
                                  : seg_decode(data_byte[3:0]);
    assign cnt     = (r_press == 4'hF) ? 4'hF : r_press + 4'd1;
    assign lim     = (r_thr == 4'hF) ? 4'hF : r_thr + 4'd1;
    assign rel     = {1'b0, r_rel} + 7'd1;

    always_comb begin
        n_staged = r_staged;
        n_shown  = r_shown;
        n_scan   = r_scan;
        n_press  = r_press;
        n_rel    = r_rel;
        n_notify = r_notify;
        n_signal = r_signal;
        n_sw     = r_sw;
        n_tx     = r_tx;
        n_den    = r_den;
        n_dseg   = r_dseg;
        unique case (t_action'(i_s_tuser))
            ACT_WRITE: begin
                if (r_notify) begin
                    n_tx = {4'd0, r_sw};
                end
                n_staged[slot] = seg_val;
                if (data_byte[7]) begin
                    n_shown = n_staged;
                end
            end
            ACT_READ: begin
                if (r_notify) begin
                    n_tx = {4'd0, r_sw};
                end
                n_notify = 1'b0;
                n_signal = 1'b0;
            end
            ACT_TICK: begin
                n_den  = DIG_OFF & ~(4'd1 << r_scan);
                n_dseg = r_shown[r_scan];
                n_scan = r_scan + 2'd1;
                n_sw   = switch_raw;
                if (switch_raw != 4'd0) begin
                    n_rel = 6'd0;
                    if (cnt == r_thr) begin
                        n_notify = 1'b1;
                        n_signal = 1'b1;
                    end
                    n_press = (cnt > lim) ? lim : cnt;
                end else begin
                    if (r_press < r_thr) begin
                        n_press = 4'd0;
                    end
                    if (rel > {1'b0, r_hold}) begin
                        n_press = 4'd0;
                        n_rel   = r_hold;
                    end else begin
                        n_rel = rel[5:0];
                    end
                end
            end
            default: begin
            end
        endcase
        n_res.digit_enable_n = n_den;
        n_res.segments_n     = n_dseg;
        n_res.switch_signal  = n_signal;
        n_res.read_data      = n_tx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= PRESS_THRESHOLD_RST;
            r_hold   <= RELEASE_HOLD_RST;
            r_staged <= {DIGITS{SEG_BLANK}};
            r_shown  <= {DIGITS{SEG_BLANK}};
            r_scan   <= 2'd0;
            r_press  <= 4'd0;
            r_rel    <= 6'd0;
            r_notify <= 1'b0;
            r_signal <= 1'b0;
            r_sw     <= 4'd0;
            r_tx     <= 8'd0;
            r_den    <= DIG_OFF;
            r_dseg   <= SEG_BLANK;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_PRESS_THRESHOLD) begin
                    r_thr <= i_cfg_data[3:0];
                end else if (i_cfg_index == CFG_RELEASE_HOLD) begin
                    r_hold <= i_cfg_data;
                end
            end
            if (in_acc) begin
                r_staged <= n_staged;
                r_shown  <= n_shown;
                r_scan   <= n_scan;
                r_press  <= n_press;
                r_rel    <= n_rel;
                r_notify <= n_notify;
                r_signal <= n_signal;
                r_sw     <= n_sw;
                r_tx     <= n_tx;
                r_den    <= n_den;
                r_dseg   <= n_dseg;
            end
        end
    end

    // Result register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skd_valid) begin
                    r_out_valid <= 1'b1;
                    r_skd_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_acc;
                end
            end else if (in_acc) begin
                r_skd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skd_valid ? r_skd : n_res;
        end
        if (in_acc && !out_free) begin
            r_skd <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_out};

    `SSD_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skd_valid, r_out_valid)
    `SSD_ASSERT_SAME(a_notify_signal_pair, i_clk, i_rst_n, 1'b1, r_notify == r_signal)
    `SSD_ASSERT_SAME(a_digit_one_low, i_clk, i_rst_n, 1'b1,
                     (r_den == DIG_OFF) || $onehot(~r_den))
    `SSD_ASSERT_NEXT(a_read_clears, i_clk, i_rst_n,
                     in_acc && (i_s_tuser == ACT_READ), !r_notify && !r_signal)

endmodule

`default_nettype wire

// ===== dv/seven_segment_scan_with_switch_debounce_core_tb.sv =====
`timescale 1ns / 100ps

module seven_segment_scan_with_switch_debounce_core_tb;
    import ssd_pkg::*;

    localparam logic [1:0] ACT_SPARE   = 2'd3;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_SLACK = 6;
    localparam int         PHASE_ITEMS = 100;

    localparam logic [7:0] SEG_CODES [16] = '{
        8'h81, 8'hF3, 8'h49, 8'h61, 8'h33, 8'h25, 8'h05, 8'hF1,
        8'h01, 8'h21, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] data_byte;
        logic [3:0] switches;
        logic       literal;
        t_result    want;
    } t_directed_row;

    // literal rows: straight after reset, first scan step
    localparam t_directed_row DIRECTED [25] = '{
        '{ACT_SPARE, 8'h00, 4'h0, 1'b1, '{8'h00, 1'b0, 8'hFF, 4'hF}},
        '{ACT_TICK,  8'h00, 4'h0, 1'b1, '{8'h00, 1'b0, 8'hFF, 4'hE}},
        '{ACT_WRITE, 8'h00, 4'h0, 1'b0, '0},
        '{ACT_WRITE, 8'h11, 4'hF, 1'b0, '0},
        '{ACT_WRITE, 8'h62, 4'h0, 1'b0, '0},
        '{ACT_WRITE, 8'hB9, 4'h0, 1'b0, '0},
        '{ACT_TICK,  8'h00, 4'h1, 1'b0, '0},
        '{ACT_TICK,  8'hFF, 4'h2, 1'b0, '0},
        '{ACT_TICK,  8'h00, 4'h4, 1'b0, '0},
        '{ACT_TICK,  8'hFF, 4'h8, 1'b0, '0},
        '{ACT_TICK,  8'h00, 4'hF, 1'b0, '0},
        '{ACT_WRITE, 8'hFF, 4'h0, 1'b0, '0},
        '{ACT_READ,  8'h00, 4'h0, 1'b0, '0},
        '{ACT_READ,  8'hFF, 4'hF, 1'b0, '0},
        '{ACT_WRITE, 8'h0A, 4'h0, 1'b0, '0},
        '{ACT_WRITE, 8'h4B, 4'h0, 1'b0, '0},
        '{ACT_WRITE, 8'hDC, 4'h0, 1'b0, '0},
        '{ACT_TICK,  8'h00, 4'h0, 1'b0, '0},
        '{ACT_TICK,  8'h00, 4'h0, 1'b0, '0},
        '{ACT_TICK,  8'h00, 4'hF, 1'b0, '0},
        '{ACT_TICK,  8'h00, 4'h0, 1'b0, '0},
        '{ACT_WRITE, 8'h2D, 4'h0, 1'b0, '0},
        '{ACT_WRITE, 8'hBE, 4'h0, 1'b0, '0},
        '{ACT_SPARE, 8'hAA, 4'h5, 1'b0, '0},
        '{ACT_TICK,  8'h55, 4'h0, 1'b0, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;   // data_byte[7:0], switch_raw[11:8], zero pad
    logic [1:0]  i_s_tuser = '0;   // action[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;        // digit_enable_n[3:0], segments_n[11:4],
                                   // switch_signal[12], read_data[20:13], zero pad
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [5:0]  i_cfg_data = '0;

    seven_segment_scan_with_switch_debounce_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted block state
    logic [3:0] thr_setting = PRESS_THRESHOLD_RST;
    logic [5:0] hold_setting = RELEASE_HOLD_RST;
    logic [7:0] staged_slots [DIGITS] = '{default: SEG_BLANK};
    logic [7:0] shown_slots [DIGITS] = '{default: SEG_BLANK};
    logic [1:0] scan_pos = '0;
    logic [3:0] press_ticks = '0;
    logic [5:0] release_ticks = '0;
    logic       notify_pending = 1'b0;
    logic       signal_high = 1'b0;
    logic [3:0] last_switches = '0;
    logic [7:0] tx_byte = '0;
    logic [3:0] held_enable = DIG_OFF;
    logic [7:0] held_segments = SEG_BLANK;

    t_result awaited_display [$];

    int mismatches = 0;
    int requests_sent = 0;
    int spare_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int settings_used = 1;
    int burst_left = 0;

    task automatic predict_display(input logic [1:0] act, input logic [7:0] d,
                                   input logic [3:0] sw, output t_result res);
        int cnt;
        int lim;
        int rel;
        case (act)
            ACT_WRITE, ACT_READ: begin
                if (notify_pending)
                    tx_byte = {4'h0, last_switches};
                if (act == ACT_WRITE) begin
                    staged_slots[d[5:4]] = SEG_CODES[d[3:0]] & {7'h7F, ~d[6]};
                    if (d[7])
                        shown_slots = staged_slots;
                end else begin
                    notify_pending = 1'b0;
                    signal_high = 1'b0;
                end
            end
            ACT_TICK: begin
                held_enable = DIG_OFF & ~(4'b0001 << scan_pos);
                held_segments = shown_slots[scan_pos];
                scan_pos = scan_pos + 2'd1;
                last_switches = sw;
                if (sw != 4'h0) begin
                    cnt = int'(press_ticks) + 1;
                    lim = int'(thr_setting) + 1;
                    if (cnt > 15)
                        cnt = 15;
                    if (lim > 15)
                        lim = 15;
                    release_ticks = '0;
                    if (cnt == int'(thr_setting)) begin
                        signal_high = 1'b1;
                        notify_pending = 1'b1;
                    end
                    if (cnt > lim)
                        cnt = lim;
                    press_ticks = 4'(cnt);
                end else begin
                    rel = int'(release_ticks) + 1;
                    if (press_ticks < thr_setting)
                        press_ticks = '0;
                    if (rel > int'(hold_setting)) begin
                        press_ticks = '0;
                        rel = int'(hold_setting);
                    end
                    release_ticks = 6'(rel);
                end
            end
            default: ;
        endcase
        res.digit_enable_n = held_enable;
        res.segments_n = held_segments;
        res.switch_signal = signal_high;
        res.read_data = tx_byte;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got 0x%0h want 0x%0h at result %0d",
                 what, got, want, results_seen);
        mismatches++;
    endtask

    task automatic hold_off(input int cycles);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_request(input logic [1:0] act, input logic [7:0] d,
                                input logic [3:0] sw, input logic use_lit,
                                input t_result lit);
        t_result res;
        i_s_tvalid <= 1'b1;
        i_s_tuser <= act;
        i_s_tdata <= {4'h0, sw, d};
        do @(posedge i_clk); while (!o_s_tready);
        predict_display(act, d, sw, res);
        awaited_display.push_back(use_lit ? lit : res);
        requests_sent++;
        if (act == ACT_SPARE)
            spare_sent++;
    endtask

    task automatic paced_send(input logic [1:0] act, input logic [7:0] d,
                              input logic [3:0] sw, input logic use_lit,
                              input t_result lit);
        send_request(act, d, sw, use_lit, lit);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 6));
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_for_drain();
        i_s_tvalid <= 1'b0;
        while (awaited_display.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [5:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_PRESS_THRESHOLD)
            thr_setting = val[3:0];
        else if (idx == CFG_RELEASE_HOLD)
            hold_setting = val;
        cfg_writes++;
    endtask

    task automatic apply_settings(input logic [3:0] thr, input logic [5:0] hold,
                                  input logic poke_unused);
        wait_for_drain();
        write_register(CFG_PRESS_THRESHOLD, {2'b00, thr});
        write_register(CFG_RELEASE_HOLD, hold);
        if (poke_unused)
            write_register(CFG_UNUSED, 6'(~hold));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic run_random_phase(input int budget);
        int start;
        int n;
        int k;
        logic [7:0] d;
        start = requests_sent - spare_sent;
        while (requests_sent - spare_sent - start < budget) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // fill all four slots, load on the last
                    for (k = 0; k < 4; k++) begin
                        d = 8'($urandom_range(0, 255));
                        d[5:4] = 2'(k);
                        if (k == 3)
                            d[7] = 1'b1;
                        paced_send(ACT_WRITE, d, 4'($urandom_range(0, 15)), 1'b0, '0);
                    end
                end
                3, 4, 5, 6: begin
                    // press with bounce, acknowledge, then release
                    n = $urandom_range(1, int'(thr_setting) + 3);
                    for (k = 0; k < n; k++) begin
                        if ($urandom_range(0, 7) == 0)
                            paced_send(ACT_READ, 8'($urandom_range(0, 255)),
                                       4'($urandom_range(0, 15)), 1'b0, '0);
                        else if ($urandom_range(0, 9) == 0)
                            paced_send(ACT_TICK, 8'($urandom_range(0, 255)), 4'h0, 1'b0, '0);
                        else
                            paced_send(ACT_TICK, 8'($urandom_range(0, 255)),
                                       4'($urandom_range(1, 15)), 1'b0, '0);
                    end
                    paced_send(ACT_READ, 8'($urandom_range(0, 255)),
                               4'($urandom_range(0, 15)), 1'b0, '0);
                    n = $urandom_range(0, int'(hold_setting) + 3);
                    for (k = 0; k < n; k++) begin
                        if ($urandom_range(0, 9) == 0)
                            paced_send(ACT_WRITE, 8'($urandom_range(0, 255)),
                                       4'($urandom_range(0, 15)), 1'b0, '0);
                        else
                            paced_send(ACT_TICK, 8'($urandom_range(0, 255)), 4'h0, 1'b0, '0);
                    end
                end
                default: begin
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++)
                        paced_send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                   4'($urandom_range(0, 15)), 1'b0, '0);
                end
            endcase
        end
    endtask

    // receiver back-pressure
    int       stall_left = 0;
    int       stall_mode = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(8, 40);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= 1'($urandom_range(0, 1));
            default: i_m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin : check_display
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[20:0];
            if (awaited_display.size() == 0) begin
                report_mismatch("unexpected result", int'(o_m_tdata), 0);
            end else begin
                want = awaited_display.pop_front();
                if (got.digit_enable_n !== want.digit_enable_n)
                    report_mismatch("digit_enable_n", got.digit_enable_n,
                                    want.digit_enable_n);
                if (got.segments_n !== want.segments_n)
                    report_mismatch("segments_n", got.segments_n, want.segments_n);
                if (got.switch_signal !== want.switch_signal)
                    report_mismatch("switch_signal", got.switch_signal, want.switch_signal);
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (o_m_tdata[23:21] !== 3'b000)
                    report_mismatch("tdata pad", o_m_tdata[23:21], 0);
                results_seen++;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, awaited_display.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i])
            paced_send(DIRECTED[i].act, DIRECTED[i].data_byte, DIRECTED[i].switches,
                       DIRECTED[i].literal, DIRECTED[i].want);

        run_random_phase(PHASE_ITEMS);
        apply_settings(4'd1, 6'd0, 1'b0);
        run_random_phase(PHASE_ITEMS);
        apply_settings(4'd14, 6'd63, 1'b0);
        run_random_phase(PHASE_ITEMS);
        apply_settings(4'd3, 6'd42, 1'b1);
        run_random_phase(PHASE_ITEMS);
        apply_settings(4'($urandom_range(1, 14)), 6'($urandom_range(0, 63)), 1'b0);
        run_random_phase(PHASE_ITEMS);

        wait_for_drain();
        $display("covered %0d requests (%0d of the unused kind), %0d results checked",
                 requests_sent, spare_sent, results_seen);
        $display("over %0d debounce settings with %0d register writes, %0d mismatches",
                 settings_used, cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ssd_pkg.sv
rtl/seven_segment_scan_with_switch_debounce_core.sv
dv/seven_segment_scan_with_switch_debounce_core_tb.sv
